[src/ffsm_pkg.sv]
// ----------------------------------------------------------------------------
// Force-effect slot manager package
// Shared sizes, request codes and the structures that pass between modules.
// ----------------------------------------------------------------------------
package ffsm_pkg;

    // Pool size and derived widths.
    localparam int NUM_SLOTS = 20;
    localparam int IDX_W     = $clog2(NUM_SLOTS);

    // Fixed field widths.
    localparam int REQ_W    = 3;
    localparam int ETYPE_W  = 4;
    localparam int SLOT_W   = 5;
    localparam int DUR_W    = 16;
    localparam int OP_W     = 2;
    localparam int LOOP_W   = 8;
    localparam int CTRL_W   = 3;
    localparam int DELTA_W  = 16;
    localparam int STAT_W   = 2;
    localparam int FREE_W   = 5;
    localparam int MASK_W   = 20;
    localparam int RT_W     = 32;
    localparam int TMASK_W  = 16;
    localparam int VEC_W    = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;

    localparam logic [DUR_W-1:0]   INFINITE_DUR = '1;
    localparam logic [TMASK_W-1:0] TMASK_RESET  = '1;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OPER   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEVCTL = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd6;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_SOLO  = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // Device control codes.
    localparam logic [CTRL_W-1:0] CTL_ENABLE   = 3'd0;
    localparam logic [CTRL_W-1:0] CTL_DISABLE  = 3'd1;
    localparam logic [CTRL_W-1:0] CTL_STOP_ALL = 3'd2;
    localparam logic [CTRL_W-1:0] CTL_RESET    = 3'd3;
    localparam logic [CTRL_W-1:0] CTL_PAUSE    = 3'd4;
    localparam logic [CTRL_W-1:0] CTL_CONTINUE = 3'd5;

    // Create outcomes.
    localparam logic [STAT_W-1:0] LOAD_OK    = 2'd0;
    localparam logic [STAT_W-1:0] LOAD_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] LOAD_ERROR = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ETYPE_W-1:0] effect_type;
        logic [SLOT_W-1:0]  slot;
        logic [DUR_W-1:0]   duration_ms;
        logic [OP_W-1:0]    operation;
        logic [LOOP_W-1:0]  loop_count;
        logic [CTRL_W-1:0]  control_code;
        logic [DELTA_W-1:0] delta_ms;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] alloc_slot;
        logic [STAT_W-1:0] load_status;
        logic [FREE_W-1:0] free_count;
        logic              paused;
        logic              actuators_on;
        logic              alloc_playing;
        logic [MASK_W-1:0] playing_mask;
    } t_rsp;

    typedef struct packed {
        logic start;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic last_slot;
    } t_dp_status;

endpackage

[src/ffsm_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface ffsm_req_if;
    import ffsm_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [ETYPE_W-1:0] effect_type;
    logic [SLOT_W-1:0]  slot;
    logic [DUR_W-1:0]   duration_ms;
    logic [OP_W-1:0]    operation;
    logic [LOOP_W-1:0]  loop_count;
    logic [CTRL_W-1:0]  control_code;
    logic [DELTA_W-1:0] delta_ms;

    modport source (
        output valid, req_type, effect_type, slot, duration_ms, operation,
               loop_count, control_code, delta_ms,
        input  ready
    );

    modport sink (
        input  valid, req_type, effect_type, slot, duration_ms, operation,
               loop_count, control_code, delta_ms,
        output ready
    );
endinterface

[src/ffsm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Status channel
// Valid/ready channel that carries one status snapshot word.
// ----------------------------------------------------------------------------
interface ffsm_rsp_if;
    import ffsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] alloc_slot;
    logic [STAT_W-1:0] load_status;
    logic [FREE_W-1:0] free_count;
    logic              paused;
    logic              actuators_on;
    logic              alloc_playing;
    logic [MASK_W-1:0] playing_mask;

    modport source (
        output valid, alloc_slot, load_status, free_count, paused, actuators_on,
               alloc_playing, playing_mask,
        input  ready
    );

    modport sink (
        input  valid, alloc_slot, load_status, free_count, paused, actuators_on,
               alloc_playing, playing_mask,
        output ready
    );
endinterface

[src/ffsm_ctrl.sv]
// ----------------------------------------------------------------------------
// Slot manager controller
// Sequences accept, slot sweep and publication of the status word.
// ----------------------------------------------------------------------------
module ffsm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ffsm_pkg::t_dp_cmd     o_cmd,
    input  ffsm_pkg::t_dp_status  i_status
);
    import ffsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.step = 1'b1;
                if (i_status.last_slot) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/ffsm_dpath.sv]
// ----------------------------------------------------------------------------
// Slot manager datapath
// Slot state, the per-slot update unit, summary accumulators and output word.
// ----------------------------------------------------------------------------
module ffsm_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ffsm_pkg::TMASK_W-1:0] i_cfg_wr_data,
    input  ffsm_pkg::t_req              i_req,
    input  ffsm_pkg::t_dp_cmd           i_cmd,
    output ffsm_pkg::t_dp_status        o_status,
    output ffsm_pkg::t_rsp              o_rsp
);
    import ffsm_pkg::*;

    // Slot state, one entry per slot, accessed at the sweep index only.
    logic              r_occ   [NUM_SLOTS];
    logic [LOOP_W-1:0] r_loops [NUM_SLOTS];
    logic [RT_W-1:0]   r_rt    [NUM_SLOTS];
    logic [DUR_W-1:0]  r_dur   [NUM_SLOTS];

    // Global state.
    logic [TMASK_W-1:0] r_type_mask;
    logic               r_running;
    logic               r_act;
    logic [SLOT_W-1:0]  r_last_alloc;
    logic [STAT_W-1:0]  r_last_status;
    logic               r_search;
    logic [IDX_W-1:0]   r_idx;

    // Latched request.
    t_req r_req;
    logic r_slot_ok;

    // Summary accumulators and the output word.
    logic [FREE_W-1:0] r_free;
    logic [VEC_W-1:0]  r_vec;
    logic              r_alloc_play;
    t_rsp              r_rsp;

    // Per-slot next values.
    logic              n_occ;
    logic [LOOP_W-1:0] n_loops;
    logic [RT_W-1:0]   n_rt;
    logic [DUR_W-1:0]  n_dur;
    logic [SLOT_W-1:0] n_last_alloc;
    logic [STAT_W-1:0] n_last_status;
    logic              n_search;

    logic              cur_occ;
    logic [LOOP_W-1:0] cur_loops;
    logic [RT_W-1:0]   cur_rt;
    logic [DUR_W-1:0]  cur_dur;
    logic [SLOT_W-1:0] slot_num;
    logic              hit;
    logic [RT_W:0]     rt_sum;
    logic [RT_W-1:0]   rt_sat;
    logic              in_slot_ok;

    assign cur_occ   = r_occ[r_idx];
    assign cur_loops = r_loops[r_idx];
    assign cur_rt    = r_rt[r_idx];
    assign cur_dur   = r_dur[r_idx];
    assign slot_num  = SLOT_W'(r_idx) + SLOT_W'(1);
    assign hit       = r_slot_ok && (r_req.slot == slot_num);
    assign rt_sum    = {1'b0, cur_rt} + (RT_W+1)'(r_req.delta_ms);
    assign rt_sat    = rt_sum[RT_W] ? '1 : rt_sum[RT_W-1:0];

    assign in_slot_ok = (i_req.slot != '0) && (i_req.slot <= SLOT_W'(NUM_SLOTS));

    assign o_status.last_slot = (r_idx == IDX_W'(NUM_SLOTS - 1));

    always_comb begin
        n_occ         = cur_occ;
        n_loops       = cur_loops;
        n_rt          = cur_rt;
        n_dur         = cur_dur;
        n_last_alloc  = r_last_alloc;
        n_last_status = r_last_status;
        n_search      = r_search;
        case (r_req.req_type)
            REQ_CREATE: begin
                if (r_search && !cur_occ) begin
                    n_occ         = 1'b1;
                    n_last_alloc  = slot_num;
                    n_last_status = LOAD_OK;
                    n_search      = 1'b0;
                end
            end
            REQ_SET: begin
                if (hit) begin
                    n_occ   = 1'b1;
                    n_loops = '0;
                    n_rt    = '0;
                    n_dur   = r_req.duration_ms;
                end
            end
            REQ_FREE: begin
                if (hit) begin
                    n_occ   = 1'b0;
                    n_loops = '0;
                    n_rt    = '0;
                end
            end
            REQ_OPER: begin
                if (r_slot_ok) begin
                    case (r_req.operation)
                        OP_STOP: begin
                            if (hit) n_loops = '0;
                        end
                        OP_START: begin
                            if (hit) n_loops = r_req.loop_count;
                        end
                        OP_SOLO: begin
                            n_loops = hit ? r_req.loop_count : '0;
                        end
                        default: ;
                    endcase
                end
            end
            REQ_DEVCTL: begin
                case (r_req.control_code)
                    CTL_STOP_ALL: n_loops = '0;
                    CTL_RESET: begin
                        n_occ   = 1'b0;
                        n_loops = '0;
                        n_rt    = '0;
                    end
                    default: ;
                endcase
            end
            REQ_TICK: begin
                if (cur_occ && (cur_loops != '0) && r_running) begin
                    if ((rt_sat > RT_W'(cur_dur)) && (cur_dur != INFINITE_DUR)) begin
                        n_loops = cur_loops - LOOP_W'(1);
                        n_rt    = '0;
                    end else begin
                        n_rt = rt_sat;
                    end
                end
            end
            default: ;
        endcase
    end

    // Slot state arrays.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_occ[k]   <= 1'b0;
                r_loops[k] <= '0;
                r_rt[k]    <= '0;
                r_dur[k]   <= '0;
            end
        end else if (i_cmd.step) begin
            r_occ[r_idx]   <= n_occ;
            r_loops[r_idx] <= n_loops;
            r_rt[r_idx]    <= n_rt;
            r_dur[r_idx]   <= n_dur;
        end
    end

    // Global state: request-level effects on accept, slot-level during sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_mask   <= TMASK_RESET;
            r_running     <= 1'b0;
            r_act         <= 1'b1;
            r_last_alloc  <= '0;
            r_last_status <= LOAD_ERROR;
            r_search      <= 1'b0;
            r_idx         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_type_mask <= i_cfg_wr_data;
            end
            if (i_cmd.start) begin
                r_idx    <= '0;
                r_search <= 1'b0;
                unique case (i_req.req_type)
                    REQ_CREATE: begin
                        r_last_alloc <= '0;
                        if (r_type_mask[i_req.effect_type]) begin
                            r_last_status <= LOAD_FULL;
                            r_search      <= 1'b1;
                        end else begin
                            r_last_status <= LOAD_ERROR;
                        end
                    end
                    REQ_OPER: begin
                        if (in_slot_ok && ((i_req.operation == OP_START) ||
                                           (i_req.operation == OP_SOLO))) begin
                            r_running <= 1'b1;
                        end
                    end
                    REQ_DEVCTL: begin
                        case (i_req.control_code)
                            CTL_ENABLE:   r_act <= 1'b1;
                            CTL_DISABLE:  r_act <= 1'b0;
                            CTL_RESET: begin
                                r_running     <= 1'b0;
                                r_act         <= 1'b1;
                                r_last_alloc  <= '0;
                                r_last_status <= LOAD_ERROR;
                            end
                            CTL_PAUSE:    r_running <= 1'b0;
                            CTL_CONTINUE: r_running <= 1'b1;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end else if (i_cmd.step) begin
                r_idx         <= r_idx + IDX_W'(1);
                r_last_alloc  <= n_last_alloc;
                r_last_status <= n_last_status;
                r_search      <= n_search;
            end
        end
    end

    // Request latch, summary accumulators and the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req        <= i_req;
            r_slot_ok    <= in_slot_ok;
            r_free       <= '0;
            r_vec        <= '0;
            r_alloc_play <= 1'b0;
        end else if (i_cmd.step) begin
            if (!n_occ) begin
                r_free <= r_free + FREE_W'(1);
            end
            r_vec[r_idx] <= n_occ && (n_loops != '0) && r_running;
            if (n_last_alloc == slot_num) begin
                r_alloc_play <= (n_loops != '0);
            end
        end
        if (i_cmd.publish) begin
            r_rsp.alloc_slot    <= r_last_alloc;
            r_rsp.load_status   <= r_last_status;
            r_rsp.free_count    <= r_free;
            r_rsp.paused        <= !r_running;
            r_rsp.actuators_on  <= r_act;
            r_rsp.alloc_playing <= r_alloc_play;
            r_rsp.playing_mask  <= r_vec[MASK_W-1:0];
        end
    end

    assign o_rsp = r_rsp;

endmodule

[src/force_effect_slot_manager.sv]
// ----------------------------------------------------------------------------
// Force-effect slot manager
// Pool of force-effect slots with allocation, playback bookkeeping and status.
// ----------------------------------------------------------------------------
// Usage. Requests arrive as words on the i_req channel and every request
// returns exactly one status word on the o_rsp channel, a snapshot taken after
// the request has been applied. The supported-type mask is written through
// i_cfg_wr_en and i_cfg_wr_data while the block is idle.
// Sequence. A request word is taken while the block is idle, after which the
// datapath sweeps the pool one slot per cycle through the single per-slot
// update unit and then publishes the status word into the output register.
// The block accepts no new request until that status word has been published.
// Stalls. The status word sits in an output register, so the next request may
// be accepted while the previous word waits. If a second word is finished
// before the first is taken, the block holds it and stops accepting requests
// until the receiver raises ready.
// Reset. The synchronous active-low reset clears every slot, stops playback,
// enables the actuators, sets the last load status to error and restores the
// supported-type mask to all ones. No clearing pass is needed.
// ----------------------------------------------------------------------------
module force_effect_slot_manager (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [ffsm_pkg::TMASK_W-1:0] i_cfg_wr_data,
    ffsm_req_if.sink                     i_req,
    ffsm_rsp_if.source                   o_rsp
);
    import ffsm_pkg::*;

    t_req       req_word;
    t_rsp       rsp_word;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Gather the request fields into one word for the datapath.
    assign req_word.req_type     = i_req.req_type;
    assign req_word.effect_type  = i_req.effect_type;
    assign req_word.slot         = i_req.slot;
    assign req_word.duration_ms  = i_req.duration_ms;
    assign req_word.operation    = i_req.operation;
    assign req_word.loop_count   = i_req.loop_count;
    assign req_word.control_code = i_req.control_code;
    assign req_word.delta_ms     = i_req.delta_ms;

    // The controller owns the handshakes; the datapath owns the slot and status state.
    ffsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    ffsm_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_word),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_rsp         (rsp_word)
    );

    // Spread the registered status word over the output channel.
    assign o_rsp.alloc_slot    = rsp_word.alloc_slot;
    assign o_rsp.load_status   = rsp_word.load_status;
    assign o_rsp.free_count    = rsp_word.free_count;
    assign o_rsp.paused        = rsp_word.paused;
    assign o_rsp.actuators_on  = rsp_word.actuators_on;
    assign o_rsp.alloc_playing = rsp_word.alloc_playing;
    assign o_rsp.playing_mask  = rsp_word.playing_mask;

endmodule

[verif/force_effect_slot_manager_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Force-effect slot manager testbench
// Drives request words into the slot pool and checks every status word. A
// tracker class keeps its own copy of the pool and predicts each status word.
// The run has a short directed part and then random phases. Each random phase
// uses a different supported-type mask; gaps and stalls are random but in the third.
// ----------------------------------------------------------------------------
module force_effect_slot_manager_test;
    import ffsm_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 100;

    // ------------------------------------------------------------------------
    // Pool tracker: a private copy of the slot pool. It is updated on every
    // accepted request word and holds the status words still to come back.
    // ------------------------------------------------------------------------
    class pool_status_tracker;
        logic [TMASK_W-1:0] type_mask;
        bit                 occupied [NUM_SLOTS];
        logic [LOOP_W-1:0]  loops    [NUM_SLOTS];
        logic [RT_W-1:0]    run_ms   [NUM_SLOTS];
        logic [DUR_W-1:0]   dur_ms   [NUM_SLOTS];
        bit                 running;
        bit                 act_en;
        logic [SLOT_W-1:0]  last_alloc;
        logic [STAT_W-1:0]  last_status;
        t_rsp               status_snapshots_q[$];
        int unsigned        errors;

        function new();
            type_mask = TMASK_RESET;
            foreach (dur_ms[i]) dur_ms[i] = '0;
            clear_pool();
            errors = 0;
        endfunction

        // Device reset keeps the durations and the type mask.
        function void clear_pool();
            foreach (occupied[i]) begin
                occupied[i] = 0;
                loops[i]    = '0;
                run_ms[i]   = '0;
            end
            running     = 0;
            act_en      = 1;
            last_alloc  = '0;
            last_status = LOAD_ERROR;
        endfunction

        function int pending();
            return status_snapshots_q.size();
        endfunction

        function void note_request(t_req r);
            t_rsp        snap;
            bit          slot_ok;
            int unsigned idx;
            logic [RT_W:0] sum;

            slot_ok = (r.slot >= 1) && (r.slot <= NUM_SLOTS);
            idx     = slot_ok ? r.slot - 1 : 0;
            case (r.req_type)
                REQ_CREATE: begin
                    last_alloc = '0;
                    if (!type_mask[r.effect_type]) begin
                        last_status = LOAD_ERROR;
                    end else begin
                        // Lowest free slot wins; its loops and runtime are kept.
                        last_status = LOAD_FULL;
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (!occupied[i]) begin
                                occupied[i] = 1;
                                last_status = LOAD_OK;
                                last_alloc  = SLOT_W'(i + 1);
                                break;
                            end
                        end
                    end
                end
                REQ_SET: begin
                    if (slot_ok) begin
                        occupied[idx] = 1;
                        loops[idx]    = '0;
                        run_ms[idx]   = '0;
                        dur_ms[idx]   = r.duration_ms;
                    end
                end
                REQ_FREE: begin
                    if (slot_ok) begin
                        occupied[idx] = 0;
                        loops[idx]    = '0;
                        run_ms[idx]   = '0;
                    end
                end
                REQ_OPER: begin
                    if (slot_ok) begin
                        if (r.operation == OP_STOP) begin
                            loops[idx] = '0;
                        end else if (r.operation == OP_START || r.operation == OP_SOLO) begin
                            if (r.operation == OP_SOLO) begin
                                foreach (loops[i]) loops[i] = '0;
                            end
                            loops[idx] = r.loop_count;
                            running    = 1;
                        end
                    end
                end
                REQ_DEVCTL: begin
                    case (r.control_code)
                        CTL_ENABLE:   act_en = 1;
                        CTL_DISABLE:  act_en = 0;
                        CTL_STOP_ALL: foreach (loops[i]) loops[i] = '0;
                        CTL_RESET:    clear_pool();
                        CTL_PAUSE:    running = 0;
                        CTL_CONTINUE: running = 1;
                        default: ;
                    endcase
                end
                REQ_TICK: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (occupied[i] && loops[i] != 0 && running) begin
                            sum       = {1'b0, run_ms[i]} + r.delta_ms;
                            run_ms[i] = sum[RT_W] ? '1 : sum[RT_W-1:0];
                            if (run_ms[i] > dur_ms[i] && dur_ms[i] != INFINITE_DUR) begin
                                loops[i]  = loops[i] - 1'b1;
                                run_ms[i] = '0;
                            end
                        end
                    end
                end
                default: ;
            endcase

            snap               = '0;
            snap.alloc_slot    = last_alloc;
            snap.load_status   = last_status;
            snap.paused        = !running;
            snap.actuators_on  = act_en;
            snap.alloc_playing = (last_alloc >= 1) && (last_alloc <= NUM_SLOTS)
                                 && (loops[last_alloc - 1] != 0);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!occupied[i])
                    snap.free_count = snap.free_count + 1'b1;
                if (occupied[i] && loops[i] != 0 && running && i < MASK_W)
                    snap.playing_mask[i] = 1'b1;
            end
            status_snapshots_q.push_back(snap);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_status(t_rsp got);
            t_rsp want;

            if (status_snapshots_q.size() == 0) begin
                errors++;
                $error("status word arrived with no request outstanding");
                return;
            end
            want = status_snapshots_q.pop_front();
            compare_field("alloc_slot",    want.alloc_slot,    got.alloc_slot);
            compare_field("load_status",   want.load_status,   got.load_status);
            compare_field("free_count",    want.free_count,    got.free_count);
            compare_field("paused",        want.paused,        got.paused);
            compare_field("actuators_on",  want.actuators_on,  got.actuators_on);
            compare_field("alloc_playing", want.alloc_playing, got.alloc_playing);
            compare_field("playing_mask",  want.playing_mask,  got.playing_mask);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [TMASK_W-1:0] i_cfg_wr_data;

    ffsm_req_if req_ch ();
    ffsm_rsp_if rsp_ch ();

    force_effect_slot_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_ch.sink),
        .o_rsp         (rsp_ch.source)
    );

    pool_status_tracker tracker = new();

    // When clear, neither side leaves gaps, so words go back to back.
    bit          idling_on = 1;
    int unsigned words_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;

        if (!idling_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0:       return INFINITE_DUR;
            1:       return DUR_W'($urandom);
            default: return DUR_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            8:       return DELTA_W'($urandom);
            9:       return '1;
            default: return DELTA_W'($urandom_range(0, 20));
        endcase
    endfunction

    // A request with every field random. Slots are mostly in range and the
    // device reset is kept rare, since it wipes the pool.
    function automatic t_req random_request();
        t_req r;

        r.req_type     = REQ_W'($urandom_range(0, 7));
        r.effect_type  = ETYPE_W'($urandom);
        r.slot         = ($urandom_range(0, 5) == 0) ? SLOT_W'($urandom)
                                                     : SLOT_W'($urandom_range(1, NUM_SLOTS));
        r.duration_ms  = pick_duration();
        r.operation    = OP_W'($urandom);
        r.loop_count   = ($urandom_range(0, 3) == 0) ? LOOP_W'($urandom)
                                                     : LOOP_W'($urandom_range(0, 4));
        r.control_code = CTRL_W'($urandom);
        if (r.control_code == CTL_RESET && $urandom_range(0, 3) != 0)
            r.control_code = CTL_CONTINUE;
        r.delta_ms     = pick_delta();
        return r;
    endfunction

    // Presents one request word after a random gap and returns at the rising
    // edge that accepts it. Valid stays high when no gap is wanted.
    task automatic send_request(t_req r);
        int gap;

        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type     = r.req_type;
        req_ch.effect_type  = r.effect_type;
        req_ch.slot         = r.slot;
        req_ch.duration_ms  = r.duration_ms;
        req_ch.operation    = r.operation;
        req_ch.loop_count   = r.loop_count;
        req_ch.control_code = r.control_code;
        req_ch.delta_ms     = r.delta_ms;
        req_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.note_request(r);
        words_sent++;
    endtask

    // Builds a request from the given codes, other fields random.
    task automatic send_coded(logic [REQ_W-1:0] kind, logic [SLOT_W-1:0] slot_no,
                              logic [OP_W-1:0] op, logic [CTRL_W-1:0] ctl);
        t_req r;

        r              = random_request();
        r.req_type     = kind;
        r.slot         = slot_no;
        r.operation    = op;
        r.control_code = ctl;
        send_request(r);
    endtask

    // The register is only written once every status word is back.
    task automatic write_type_mask(logic [TMASK_W-1:0] value);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        tracker.type_mask = value;
    endtask

    // The life of one effect: create it, load its duration, start it and let
    // it run for a few ticks, sometimes ending with a stop or a free.
    task automatic play_effect_sequence();
        t_req              r;
        logic [SLOT_W-1:0] target;
        int                n_ticks;

        r          = random_request();
        r.req_type = REQ_CREATE;
        send_request(r);
        target = (tracker.last_alloc != 0) ? tracker.last_alloc
                                           : SLOT_W'($urandom_range(1, NUM_SLOTS));
        r             = random_request();
        r.req_type    = REQ_SET;
        r.slot        = target;
        send_request(r);
        r             = random_request();
        r.req_type    = REQ_OPER;
        r.slot        = target;
        r.operation   = ($urandom_range(0, 7) == 0) ? OP_SOLO : OP_START;
        r.loop_count  = LOOP_W'($urandom_range(1, 3));
        send_request(r);
        n_ticks = $urandom_range(1, 6);
        repeat (n_ticks) begin
            r          = random_request();
            r.req_type = REQ_TICK;
            send_request(r);
        end
        case ($urandom_range(0, 5))
            0, 1: send_coded(REQ_FREE, target, OP_STOP, CTL_ENABLE);
            2:    send_coded(REQ_OPER, target, OP_STOP, CTL_ENABLE);
            default: ;
        endcase
    endtask

    // Receiver: ready runs high for a while, then drops for a random stall.
    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int hold;
            int stall;

            @(negedge i_clk);
            rsp_ch.ready = 1'b1;
            hold = $urandom_range(1, 12);
            repeat (hold) @(negedge i_clk);
            stall = pick_gap();
            if (stall != 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // Status words are taken at the rising edge at which valid and ready meet.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_status('{alloc_slot:    rsp_ch.alloc_slot,
                                   load_status:   rsp_ch.load_status,
                                   free_count:    rsp_ch.free_count,
                                   paused:        rsp_ch.paused,
                                   actuators_on:  rsp_ch.actuators_on,
                                   alloc_playing: rsp_ch.alloc_playing,
                                   playing_mask:  rsp_ch.playing_mask});
        end
    end

    // Watchdog: a quiet count grows while no word moves on either channel and
    // restarts on any transfer; the run is declared hung when it reaches WATCHDOG_LIMIT.
    initial begin
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [TMASK_W-1:0] phase_mask [5];

        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.effect_type  = '0;
        req_ch.slot         = '0;
        req_ch.duration_ms  = '0;
        req_ch.operation    = '0;
        req_ch.loop_count   = '0;
        req_ch.control_code = '0;
        req_ch.delta_ms     = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Types 0 and 15 are masked off so that both ends of
        // the type code see the unsupported case.
        write_type_mask(16'h7FFE);
        send_coded(REQ_QUERY, 5'd0, OP_START, CTL_ENABLE);
        send_request('{REQ_CREATE, 4'd0, 5'd0, 16'd0, OP_START, 8'd0, CTL_ENABLE, 16'd0});
        send_request('{REQ_CREATE, 4'd15, 5'd0, 16'd0, OP_START, 8'd0, CTL_ENABLE, 16'd0});
        send_request('{REQ_CREATE, 4'd1, 5'd0, 16'd0, OP_START, 8'd0, CTL_ENABLE, 16'd0});
        send_request('{REQ_SET, 4'd0, 5'd1, 16'd5, OP_START, 8'd0, CTL_ENABLE, 16'd0});
        // The last slot gets an infinite duration; slots 0 and 31 are invalid.
        send_request('{REQ_SET, 4'd0, 5'd20, INFINITE_DUR, OP_START, 8'd0, CTL_ENABLE, 16'd0});
        send_request('{REQ_SET, 4'd0, 5'd0, 16'd9, OP_START, 8'd0, CTL_ENABLE, 16'd0});
        send_request('{REQ_SET, 4'd0, 5'd31, 16'd9, OP_START, 8'd0, CTL_ENABLE, 16'd0});
        send_request('{REQ_OPER, 4'd0, 5'd1, 16'd0, OP_START, 8'd2, CTL_ENABLE, 16'd0});
        send_request('{REQ_OPER, 4'd0, 5'd20, 16'd0, OP_START, 8'd255, CTL_ENABLE, 16'd0});
        // Runtime passes the duration on the second tick, then a maximal tick.
        send_request('{REQ_TICK, 4'd0, 5'd0, 16'd0, OP_START, 8'd0, CTL_ENABLE, 16'd3});
        send_request('{REQ_TICK, 4'd0, 5'd0, 16'd0, OP_START, 8'd0, CTL_ENABLE, 16'd3});
        send_request('{REQ_TICK, 4'd0, 5'd0, 16'd0, OP_START, 8'd0, CTL_ENABLE, 16'hFFFF});
        // Start solo clears the loops of every other slot.
        send_request('{REQ_OPER, 4'd0, 5'd1, 16'd0, OP_SOLO, 8'd1, CTL_ENABLE, 16'd0});
        send_request('{REQ_OPER, 4'd0, 5'd1, 16'd0, 2'd3, 8'd7, CTL_ENABLE, 16'd0});
        send_coded(REQ_OPER, 5'd1, OP_STOP, CTL_ENABLE);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, CTL_DISABLE);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, CTL_ENABLE);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, CTL_PAUSE);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, CTL_CONTINUE);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, CTL_STOP_ALL);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, 3'd6);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, 3'd7);
        send_coded(3'd7, 5'd1, OP_START, CTL_ENABLE);
        send_coded(REQ_FREE, 5'd0, OP_START, CTL_ENABLE);
        send_coded(REQ_FREE, 5'd1, OP_START, CTL_ENABLE);
        send_coded(REQ_DEVCTL, 5'd0, OP_START, CTL_RESET);

        // Random phases, each under its own type mask. The third phase runs
        // with no gaps on either side.
        phase_mask[0] = 16'hFFFF;
        phase_mask[1] = 16'h0000;
        phase_mask[2] = TMASK_W'($urandom);
        phase_mask[3] = 16'h8001;
        phase_mask[4] = TMASK_W'($urandom) | 16'h00FF;
        for (int p = 0; p < 5; p++) begin
            int unsigned phase_end;

            write_type_mask(phase_mask[p]);
            idling_on = (p != 2);
            phase_end = words_sent + PHASE_ITEMS;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7)
                    play_effect_sequence();
                else
                    send_request(random_request());
            end
        end

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        idling_on    = 1;
        while (tracker.pending() != 0) @(posedge i_clk);
        // Leave time for any stray status word to show up.
        repeat (NUM_SLOTS + 8) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[force_effect_slot_manager.f]
src/ffsm_pkg.sv
src/ffsm_req_if.sv
src/ffsm_rsp_if.sv
src/ffsm_ctrl.sv
src/ffsm_dpath.sv
src/force_effect_slot_manager.sv
verif/force_effect_slot_manager_test.sv
